// ===== hw/rtl/opl_pkg.sv =====
// Shared types and constants for the output peak limiter.
package opl_pkg;

    localparam int LANES            = 8;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int GAIN_BITS    = 24;
    localparam int VOL_BITS     = 16;
    localparam int COEF_BITS    = 24;
    localparam int CHAN_BITS    = 4;
    localparam int GEN_BITS     = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME   = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE  = 8'd2;

    localparam logic [CHAN_BITS-1:0] CHAN_RST = 4'd2;
    localparam logic [VOL_BITS-1:0]  VOL_RST  = 16'd4096;
    localparam logic [COEF_BITS-1:0] COEF_RST = 24'd16775818;

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 24'd8388608;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_RELEASE,
        ST_APPLY,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/opl_ifs.sv =====
// Valid/ready channel interfaces for frames, results and register writes.
interface opl_frame_if
    import opl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_7;
    logic        [GEN_BITS-1:0]    generation;
    logic                          last_frame;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7, generation, last_frame,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7, generation, last_frame,
        output ready
    );
endinterface

interface opl_result_if
    import opl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_0;
    logic signed [SAMPLE_BITS-1:0] out_1;
    logic signed [SAMPLE_BITS-1:0] out_2;
    logic signed [SAMPLE_BITS-1:0] out_3;
    logic signed [SAMPLE_BITS-1:0] out_4;
    logic signed [SAMPLE_BITS-1:0] out_5;
    logic signed [SAMPLE_BITS-1:0] out_6;
    logic signed [SAMPLE_BITS-1:0] out_7;
    logic        [SAMPLE_BITS-2:0] block_peak;
    logic        [GAIN_BITS-1:0]   applied_gain;

    modport source (
        output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
               block_peak, applied_gain,
        input  ready
    );
    modport sink (
        input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
               block_peak, applied_gain,
        output ready
    );
endinterface

interface opl_cfg_if
    import opl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_DAT_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/output_peak_limiter_unit.sv =====
// Output peak limiter: volume, instant-attack / exponential-release limiter, clamp.
// A frame is accepted only in idle, so a new frame waits until the last one's result is
// registered for output. One shared multiplier is used twice per lane (volume, then gain)
// and once for the release step; the required gain comes from a one-bit-per-cycle
// restoring divider.
// Synchronous active-low reset loads register defaults, unity gain, zero peak.
module output_peak_limiter_unit
    import opl_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    opl_frame_if.sink     i_frame,
    opl_result_if.source  o_result,
    opl_cfg_if.sink       i_cfg
);

    localparam int F  = SAMPLE_BITS - 1;
    localparam int MW = SAMPLE_BITS + 3;
    localparam int AW = (MW > GAIN_BITS) ? MW : GAIN_BITS;
    localparam int BW = COEF_BITS + 1;
    localparam int PW = AW + BW;
    localparam int LB = $clog2(LANES);
    localparam int QB = GAIN_BITS - 1;
    localparam logic [F-1:0] CEIL_Q = F'(((64'd98 << F) + 64'd50) / 64'd100);
    localparam logic [4:0] DIV_LAST = 5'(QB - 1);

    t_state r_state, n_state;

    logic [CHAN_BITS-1:0]   r_chan;
    logic [VOL_BITS-1:0]    r_vol;
    logic [COEF_BITS-1:0]   r_coef;
    logic [GAIN_BITS-1:0]   r_gain;
    logic [GEN_BITS-1:0]    r_gen;
    logic [F-1:0]           r_pacc;

    logic [SAMPLE_BITS-1:0] r_smp [LANES];
    logic                   r_last;
    logic [MW-1:0]          r_mag [LANES];
    logic [MW-1:0]          r_peak;
    logic [MW:0]            r_rem;
    logic [QB-2:0]          r_quo;
    logic [GAIN_BITS-1:0]   r_req;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_res [LANES];
    logic                   r_ph;
    logic [LB-1:0]          r_lane;
    logic [4:0]             r_div_cnt;

    logic                   r_o_valid;
    logic [SAMPLE_BITS-1:0] r_o_res [LANES];
    logic [F-1:0]           r_o_peak;
    logic [GAIN_BITS-1:0]   r_o_gain;

    logic [SAMPLE_BITS-1:0] w_in_smp [LANES];
    logic                   w_accept;
    logic                   w_frame_ready;
    logic [CHAN_BITS-1:0]   w_nlanes;
    logic [CHAN_BITS-1:0]   w_nlanes_m1;
    logic                   w_lane_last;
    logic [SAMPLE_BITS-1:0] w_cur_smp;
    logic                   w_neg;
    logic [SAMPLE_BITS-1:0] w_abs;
    logic [AW-1:0]          w_mul_a;
    logic [BW-1:0]          w_mul_b;
    logic [PW-1:0]          w_prod;
    logic [MW-1:0]          w_m;
    logic [MW-1:0]          w_peak_nx;
    logic                   w_limit;
    logic [MW:0]            w_shl;
    logic                   w_ge;
    logic [GAIN_BITS-1:0]   w_diff;
    logic [BW-1:0]          w_coef_c;
    logic [GAIN_BITS-1:0]   w_step;
    logic [GAIN_BITS-1:0]   w_g2;
    logic [PW-1:0]          w_o_full;
    logic [F-1:0]           w_o;
    logic [SAMPLE_BITS-1:0] w_o_signed;
    logic                   w_out_free;

    assign w_in_smp[0] = i_frame.sample_0;
    assign w_in_smp[1] = i_frame.sample_1;
    assign w_in_smp[2] = i_frame.sample_2;
    assign w_in_smp[3] = i_frame.sample_3;
    assign w_in_smp[4] = i_frame.sample_4;
    assign w_in_smp[5] = i_frame.sample_5;
    assign w_in_smp[6] = i_frame.sample_6;
    assign w_in_smp[7] = i_frame.sample_7;

    assign w_accept   = i_frame.valid && w_frame_ready;
    assign w_out_free = !r_o_valid || o_result.ready;

    always_comb begin
        if (r_chan == '0) begin
            w_nlanes = CHAN_BITS'(1);
        end else if (r_chan > CHAN_BITS'(MAX_CHANNELS)) begin
            w_nlanes = CHAN_BITS'(MAX_CHANNELS);
        end else begin
            w_nlanes = r_chan;
        end
    end
    assign w_nlanes_m1 = w_nlanes - CHAN_BITS'(1);
    assign w_lane_last = (r_lane == w_nlanes_m1[LB-1:0]);

    assign w_cur_smp = r_smp[r_lane];
    assign w_neg     = w_cur_smp[SAMPLE_BITS-1];
    assign w_abs     = w_neg ? (~w_cur_smp + SAMPLE_BITS'(1)) : w_cur_smp;

    assign w_diff   = (r_gain < UNITY_GAIN) ? (UNITY_GAIN - r_gain) : '0;
    assign w_coef_c = (BW'(1) << COEF_BITS) - BW'(r_coef);

    // shared multiplier
    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);

    assign w_m       = MW'((r_prod + PW'(2048)) >> 12);
    assign w_peak_nx = (w_m > r_peak) ? w_m : r_peak;
    assign w_limit   = w_peak_nx > MW'(CEIL_Q);

    assign w_shl = {r_rem[MW-1:0], 1'b0};
    assign w_ge  = w_shl >= {1'b0, r_peak};

    assign w_step = GAIN_BITS'((r_prod + PW'((64'd1 << COEF_BITS) - 64'd1)) >> COEF_BITS);
    assign w_g2   = r_gain + w_step;

    assign w_o_full   = (r_prod + (PW'(1) << 22)) >> 23;
    assign w_o        = (w_o_full > PW'(CEIL_Q)) ? CEIL_Q : w_o_full[F-1:0];
    assign w_o_signed = w_neg ? (SAMPLE_BITS'(0) - {1'b0, w_o}) : {1'b0, w_o};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (r_ph && w_lane_last) n_state = w_limit ? ST_DIVIDE : ST_RELEASE;
            end
            ST_DIVIDE: begin
                if (r_div_cnt == DIV_LAST) n_state = ST_RELEASE;
            end
            ST_RELEASE: begin
                if (r_ph || (r_req < r_gain)) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_ph && w_lane_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_frame_ready = 1'b0;
        w_mul_a       = AW'(w_abs);
        w_mul_b       = BW'(r_vol);
        unique case (r_state)
            ST_IDLE:    w_frame_ready = 1'b1;
            ST_SCALE: begin
                w_mul_a = AW'(w_abs);
                w_mul_b = BW'(r_vol);
            end
            ST_RELEASE: begin
                w_mul_a = AW'(w_diff);
                w_mul_b = w_coef_c;
            end
            ST_APPLY: begin
                w_mul_a = AW'(r_mag[r_lane]);
                w_mul_b = BW'(r_gain);
            end
            ST_DIVIDE, ST_FINISH: ;
            default: w_frame_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chan    <= CHAN_RST;
            r_vol     <= VOL_RST;
            r_coef    <= COEF_RST;
            r_gain    <= UNITY_GAIN;
            r_gen     <= '0;
            r_pacc    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_CHANNELS: r_chan <= i_cfg.data[CHAN_BITS-1:0];
                    CFG_VOLUME:   r_vol  <= i_cfg.data[VOL_BITS-1:0];
                    CFG_RELEASE:  r_coef <= i_cfg.data[COEF_BITS-1:0];
                    default: ;
                endcase
            end

            if (r_o_valid && o_result.ready && (r_state != ST_FINISH)) r_o_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        for (int k = 0; k < LANES; k++) begin
                            r_smp[k] <= w_in_smp[k];
                            r_res[k] <= '0;
                        end
                        r_last <= i_frame.last_frame;
                        r_peak <= '0;
                        r_lane <= '0;
                        r_ph   <= 1'b0;
                        if (i_frame.generation != r_gen) begin
                            r_gain <= UNITY_GAIN;
                            r_gen  <= i_frame.generation;
                        end
                    end
                end
                ST_SCALE: begin
                    r_ph <= !r_ph;
                    if (!r_ph) begin
                        r_prod <= w_prod;
                    end else begin
                        r_mag[r_lane] <= w_m;
                        r_peak        <= w_peak_nx;
                        r_lane        <= r_lane + LB'(1);
                        if (w_lane_last) begin
                            r_rem     <= (MW+1)'(CEIL_Q);
                            r_div_cnt <= '0;
                            r_req     <= UNITY_GAIN;
                        end
                    end
                end
                ST_DIVIDE: begin
                    r_rem     <= w_ge ? (w_shl - {1'b0, r_peak}) : w_shl;
                    r_quo     <= {r_quo[QB-3:0], w_ge};
                    r_div_cnt <= r_div_cnt + 5'd1;
                    if (r_div_cnt == DIV_LAST) r_req <= {1'b0, r_quo, w_ge};
                end
                ST_RELEASE: begin
                    if (!r_ph) begin
                        if (r_req < r_gain) begin
                            r_gain <= r_req;
                            r_lane <= '0;
                        end else begin
                            r_prod <= w_prod;
                            r_ph   <= 1'b1;
                        end
                    end else begin
                        r_gain <= (w_g2 > r_req) ? r_req : w_g2;
                        r_ph   <= 1'b0;
                        r_lane <= '0;
                    end
                end
                ST_APPLY: begin
                    r_ph <= !r_ph;
                    if (!r_ph) begin
                        r_prod <= w_prod;
                    end else begin
                        r_res[r_lane] <= w_o_signed;
                        if (w_o > r_pacc) r_pacc <= w_o;
                        r_lane <= r_lane + LB'(1);
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        for (int k = 0; k < LANES; k++) r_o_res[k] <= r_res[k];
                        r_o_peak  <= r_pacc;
                        r_o_gain  <= r_gain;
                        r_o_valid <= 1'b1;
                        if (r_last) r_pacc <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_frame.ready = w_frame_ready;
    assign i_cfg.ready   = 1'b1;

    assign o_result.valid        = r_o_valid;
    assign o_result.out_0        = r_o_res[0];
    assign o_result.out_1        = r_o_res[1];
    assign o_result.out_2        = r_o_res[2];
    assign o_result.out_3        = r_o_res[3];
    assign o_result.out_4        = r_o_res[4];
    assign o_result.out_5        = r_o_res[5];
    assign o_result.out_6        = r_o_res[6];
    assign o_result.out_7        = r_o_res[7];
    assign o_result.block_peak   = r_o_peak;
    assign o_result.applied_gain = r_o_gain;

    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == ST_FINISH))
        else $error("result valid raised outside finish");

    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY_GAIN)
        else $error("limiter gain above unity");

    a_peak_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_peak <= CEIL_Q))
        else $error("block peak above ceiling");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_rem < {1'b0, r_peak}))
        else $error("divider remainder not below divisor");

    a_req_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |-> (r_gain <= r_req))
        else $error("applied gain above required gain");

endmodule

// ===== test/output_peak_limiter_unit_test.sv =====
// Self-checking testbench for the output peak limiter unit.
`timescale 1ns / 1ps

module output_peak_limiter_unit_test;
    import opl_pkg::*;

    localparam logic [63:0] CEILING  = ((64'd98 << (SAMPLE_BITS_DEF - 1)) + 64'd50) / 64'd100;
    localparam logic [63:0] COEF_ONE = 64'd1 << COEF_BITS;
    localparam logic [SAMPLE_BITS_DEF-1:0] S_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS_DEF-1:0] S_MIN = 24'h800000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_LOW = 8'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONE_TOP = 8'hFF;

    typedef struct packed {
        logic [LANES-1:0][SAMPLE_BITS_DEF-1:0] samples;
        logic [GEN_BITS-1:0]                   generation;
        logic                                  last_frame;
    } frame_t;

    typedef struct packed {
        logic [LANES-1:0][SAMPLE_BITS_DEF-1:0] lanes;
        logic [SAMPLE_BITS_DEF-2:0]            peak;
        logic [GAIN_BITS-1:0]                  gain;
    } limited_t;

    class limiter_tracker;
        logic [CHAN_BITS-1:0]       chan_reg;
        logic [VOL_BITS-1:0]        vol_reg;
        logic [COEF_BITS-1:0]       coef_reg;
        logic [GAIN_BITS-1:0]       gain;
        logic [GEN_BITS-1:0]        gen_seen;
        logic [SAMPLE_BITS_DEF-2:0] peak_hold;
        limited_t                   pending_outputs[$];
        int                         mismatch_count;

        function new();
            chan_reg = CHAN_RST;
            vol_reg = VOL_RST;
            coef_reg = COEF_RST;
            gain = UNITY_GAIN;
            gen_seen = '0;
            peak_hold = '0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] data);
            case (idx)
                CFG_CHANNELS: chan_reg = data[CHAN_BITS-1:0];
                CFG_VOLUME:   vol_reg = data[VOL_BITS-1:0];
                CFG_RELEASE:  coef_reg = data[COEF_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void take_frame(frame_t f);
            limited_t    want;
            logic [63:0] mag [LANES];
            bit          neg [LANES];
            logic [63:0] v, peak, req, g, diff, step, o;
            int          n;
            n = int'(chan_reg);
            if (n < 1) n = 1;
            if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
            if (f.generation != gen_seen) begin
                gain = UNITY_GAIN;
                gen_seen = f.generation;
            end
            peak = '0;
            for (int k = 0; k < LANES; k++) begin
                v = {40'd0, f.samples[k]};
                neg[k] = v[SAMPLE_BITS_DEF-1];
                if (neg[k]) v = (~v + 64'd1) & 64'hFFFFFF;
                mag[k] = (v * vol_reg + 64'd2048) >> 12;
                if (k < n && mag[k] > peak) peak = mag[k];
            end
            if (peak > CEILING) req = (CEILING << 23) / peak;
            else req = {40'd0, UNITY_GAIN};
            g = {40'd0, gain};
            if (req < g) begin
                g = req;
            end else begin
                diff = (g < UNITY_GAIN) ? ({40'd0, UNITY_GAIN} - g) : 64'd0;
                step = (diff * (COEF_ONE - coef_reg) + (COEF_ONE - 64'd1)) >> 24;
                g = g + step;
                if (g > req) g = req;
            end
            gain = g[GAIN_BITS-1:0];
            for (int k = 0; k < LANES; k++) begin
                want.lanes[k] = '0;
                if (k < n) begin
                    o = (mag[k] * gain + (64'd1 << 22)) >> 23;
                    if (o > CEILING) o = CEILING;
                    if (o[SAMPLE_BITS_DEF-2:0] > peak_hold) peak_hold = o[SAMPLE_BITS_DEF-2:0];
                    want.lanes[k] = neg[k] ? (24'd0 - o[SAMPLE_BITS_DEF-1:0])
                                           : o[SAMPLE_BITS_DEF-1:0];
                end
            end
            want.peak = peak_hold;
            want.gain = gain;
            pending_outputs.push_back(want);
            if (f.last_frame) peak_hold = '0;
        endfunction

        function void check_output(limited_t got);
            limited_t want;
            if (pending_outputs.size() == 0) begin
                $display("%0t: result transaction with no frame pending", $time);
                mismatch_count++;
                return;
            end
            want = pending_outputs.pop_front();
            for (int k = 0; k < LANES; k++) begin
                if (got.lanes[k] !== want.lanes[k]) begin
                    $display("%0t: out_%0d expected %0d got %0d", $time, k,
                             $signed(want.lanes[k]), $signed(got.lanes[k]));
                    mismatch_count++;
                end
            end
            if (got.peak !== want.peak) begin
                $display("%0t: block_peak expected %0d got %0d", $time, want.peak, got.peak);
                mismatch_count++;
            end
            if (got.gain !== want.gain) begin
                $display("%0t: applied_gain expected %0d got %0d", $time, want.gain, got.gain);
                mismatch_count++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    limiter_tracker board = new();

    opl_frame_if  frame_ch ();
    opl_result_if result_ch ();
    opl_cfg_if    cfg_ch ();

    output_peak_limiter_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin : collect_results
        limited_t got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.lanes[0] = result_ch.out_0;
            got.lanes[1] = result_ch.out_1;
            got.lanes[2] = result_ch.out_2;
            got.lanes[3] = result_ch.out_3;
            got.lanes[4] = result_ch.out_4;
            got.lanes[5] = result_ch.out_5;
            got.lanes[6] = result_ch.out_6;
            got.lanes[7] = result_ch.out_7;
            got.peak = result_ch.block_peak;
            got.gain = result_ch.applied_gain;
            board.check_output(got);
        end
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < src_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.sample_0   <= f.samples[0];
        frame_ch.sample_1   <= f.samples[1];
        frame_ch.sample_2   <= f.samples[2];
        frame_ch.sample_3   <= f.samples[3];
        frame_ch.sample_4   <= f.samples[4];
        frame_ch.sample_5   <= f.samples[5];
        frame_ch.sample_6   <= f.samples[6];
        frame_ch.sample_7   <= f.samples[7];
        frame_ch.generation <= f.generation;
        frame_ch.last_frame <= f.last_frame;
        do @(posedge i_clk); while (!frame_ch.ready);
        board.take_frame(f);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DAT_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_register(idx, data);
    endtask

    task automatic wait_drained();
        while (board.pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    // stray: also write to indexes past the register list
    task automatic configure(input logic [CHAN_BITS-1:0] chan, input logic [VOL_BITS-1:0] vol,
                             input logic [COEF_BITS-1:0] coef, input bit stray);
        frame_ch.valid <= 1'b0;
        wait_drained();
        write_register(CFG_CHANNELS, {20'($urandom), chan});
        write_register(CFG_VOLUME, {8'($urandom), vol});
        write_register(CFG_RELEASE, coef);
        if (stray) begin
            write_register(CFG_NONE_LOW, 24'($urandom));
            write_register(CFG_NONE_TOP, 24'hFFFFFF);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic frame_t make_frame(input logic [SAMPLE_BITS_DEF-1:0] a,
                                          input logic [SAMPLE_BITS_DEF-1:0] b,
                                          input logic [SAMPLE_BITS_DEF-1:0] rest,
                                          input logic [GEN_BITS-1:0] gen, input bit last);
        frame_t f;
        f.samples[0] = a;
        f.samples[1] = b;
        for (int k = 2; k < LANES; k++) f.samples[k] = rest;
        f.generation = gen;
        f.last_frame = last;
        return f;
    endfunction

    function automatic logic [SAMPLE_BITS_DEF-1:0] random_sample(input int loud);
        logic [SAMPLE_BITS_DEF-1:0] mag;
        case (loud)
            0: mag = 24'($urandom_range(65535));
            1: mag = 24'($urandom_range(1 << 22));
            2: return 24'($urandom);
            3: mag = 24'(8388607 - $urandom_range(400000));
            default: return '0;
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic frame_t random_frame(input logic [GEN_BITS-1:0] gen);
        frame_t f;
        int     loud;
        loud = $urandom_range(4);
        for (int k = 0; k < LANES; k++)
            f.samples[k] = random_sample(($urandom_range(3) == 0) ? $urandom_range(4) : loud);
        f.generation = gen;
        f.last_frame = ($urandom_range(15) == 0);
        return f;
    endfunction

    initial begin
        logic [GEN_BITS-1:0]  gen;
        logic [CHAN_BITS-1:0] chan;
        logic [VOL_BITS-1:0]  vol;
        logic [COEF_BITS-1:0] coef;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        i_rst_n <= 1'b0;
        frame_ch.valid <= 1'b0;
        frame_ch.sample_0 <= '0;
        frame_ch.sample_1 <= '0;
        frame_ch.sample_2 <= '0;
        frame_ch.sample_3 <= '0;
        frame_ch.sample_4 <= '0;
        frame_ch.sample_5 <= '0;
        frame_ch.sample_6 <= '0;
        frame_ch.sample_7 <= '0;
        frame_ch.generation <= '0;
        frame_ch.last_frame <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: two lanes, unity volume
        send_frame(make_frame(24'd0, 24'd0, S_MAX, 16'd0, 1'b0));
        send_frame(make_frame(S_MAX, S_MAX, S_MIN, 16'd0, 1'b0));
        send_frame(make_frame(S_MIN, S_MIN, 24'd0, 16'd0, 1'b0));
        send_frame(make_frame(S_MAX, S_MIN, 24'd0, 16'd0, 1'b0));
        send_frame(make_frame(24'd100, -24'd100, 24'd0, 16'd0, 1'b0));
        send_frame(make_frame(24'd5000, -24'd5000, S_MAX, 16'hFFFF, 1'b0));
        send_frame(make_frame(24'd1, -24'd1, 24'd0, 16'hFFFF, 1'b1));
        send_frame(make_frame(24'd0, 24'd0, 24'd0, 16'hFFFF, 1'b0));

        // all lanes, max volume, instant release
        configure(4'd8, 16'hFFFF, 24'd0, 1'b0);
        send_frame(make_frame(S_MAX, S_MIN, S_MAX, 16'd1, 1'b0));
        send_frame(make_frame(24'd1000, -24'd1000, S_MIN, 16'd1, 1'b0));
        send_frame(make_frame(S_MAX, S_MAX, S_MAX, 16'd1, 1'b1));

        // zero lanes act as one, muted, slowest release
        configure(4'd0, 16'd0, 24'hFFFFFF, 1'b1);
        send_frame(make_frame(S_MAX, S_MAX, S_MAX, 16'd1, 1'b0));
        send_frame(make_frame(S_MIN, 24'd12345, S_MIN, 16'd2, 1'b0));

        // lane count above range, double volume
        configure(4'd15, 16'd8192, 24'hFFFFFF, 1'b0);
        send_frame(make_frame(24'h500000, 24'hB00000, 24'h500000, 16'd2, 1'b0));
        send_frame(make_frame(24'h100000, 24'h100000, 24'h100000, 16'd2, 1'b0));
        send_frame(make_frame(24'h100000, 24'hF00000, 24'h100000, 16'd2, 1'b1));

        gen = 16'd2;
        for (int batch = 0; batch < 18; batch++) begin
            if (batch < 6) begin
                src_idle_pct = 29;
                sink_idle_pct = 77;
            end else if (batch < 12) begin
                src_idle_pct = 77;
                sink_idle_pct = 29;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            chan = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
            case ($urandom_range(4))
                0: vol = VOL_RST;
                1: vol = 16'($urandom);
                2: vol = 16'hFFFF;
                3: vol = 16'($urandom_range(2048, 12288));
                default: vol = 16'($urandom_range(64));
            endcase
            case ($urandom_range(3))
                0: coef = COEF_RST;
                1: coef = 24'($urandom);
                2: coef = $urandom_range(1) ? 24'hFFFFFF : 24'd0;
                default: coef = 24'hFFFFFF - 24'($urandom_range(1 << 18));
            endcase
            configure(chan, vol, coef, (batch % 6) == 5);
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(31) == 0) gen = 16'($urandom);
                send_frame(random_frame(gen));
            end
        end

        frame_ch.valid <= 1'b0;
        wait_drained();
        repeat (64) @(posedge i_clk);
        if (board.mismatch_count == 0 && board.pending_outputs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
